// ===== design/hlc_pkg.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_pkg
// Shared types and constants for the horizon limit checker.
// ----------------------------------------------------------------------------
package hlc_pkg;
  localparam int MAX_POINTS = 64;
  localparam int IDX_W = $clog2(MAX_POINTS);
  localparam int CNT_W = $clog2(MAX_POINTS + 1);
  localparam logic [16:0] FULL_TURN = 17'd36000;

  localparam logic [1:0] FN_INSERT = 2'd0;
  localparam logic [1:0] FN_DELETE = 2'd1;
  localparam logic [1:0] FN_CLEAR = 2'd2;
  localparam logic [1:0] FN_CHECK = 2'd3;

  localparam logic [1:0] ST_OK = 2'd0;
  localparam logic [1:0] ST_DUP = 2'd1;
  localparam logic [1:0] ST_FULL = 2'd2;
  localparam logic [1:0] ST_BADIDX = 2'd3;

  localparam logic [1:0] MS_OTHER = 2'd0;
  localparam logic [1:0] MS_TRACK = 2'd1;
  localparam logic [1:0] MS_SLEW = 2'd2;

  localparam logic [1:0] CFG_TRACK = 2'd0;
  localparam logic [1:0] CFG_SLEW = 2'd1;
  localparam logic [1:0] CFG_GOTO = 2'd2;
  localparam logic [1:0] CFG_GDIS = 2'd3;

  // compare modes of the limit unit
  localparam logic [1:0] CMP_ZERO = 2'd0;
  localparam logic [1:0] CMP_POINT = 2'd1;
  localparam logic [1:0] CMP_INTERP = 2'd2;

  typedef struct packed {
    logic [15:0] az;
    logic signed [14:0] alt;
  } point_t;

  // per-cycle command broadcast to every cell
  typedef struct packed {
    logic ins;
    logic del;
    logic [15:0] az;
    logic signed [14:0] alt;
    logic [IDX_W-1:0] rank;
  } cell_cmd_t;
endpackage
`default_nettype wire

// ===== design/hlc_cell.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_cell
// One table slot: holds a point, shifts up on insert, down on delete.
// ----------------------------------------------------------------------------
module hlc_cell (
  input  wire logic               clk,
  input  wire logic [hlc_pkg::IDX_W-1:0] pos,
  input  wire hlc_pkg::cell_cmd_t cmd,
  input  wire hlc_pkg::point_t    lower,
  input  wire hlc_pkg::point_t    upper,
  output hlc_pkg::point_t         pt
);
  hlc_pkg::point_t pt_r, pt_nxt;
  always_comb begin
    pt_nxt = pt_r;
    if (cmd.ins) begin
      if (pos == cmd.rank) begin
        pt_nxt.az = cmd.az;
        pt_nxt.alt = cmd.alt;
      end else if (pos > cmd.rank) begin
        pt_nxt = lower;
      end
    end else if (cmd.del && pos >= cmd.rank) begin
      pt_nxt = upper;
    end
  end
  always_ff @(posedge clk) begin
    pt_r <= pt_nxt;
  end
  assign pt = pt_r;
endmodule
`default_nettype wire

// ===== design/hlc_interp.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// hlc_interp
// Two-stage exact horizon compare: operand prep, then cross-multiply.
// ----------------------------------------------------------------------------
module hlc_interp (
  input  wire logic        clk,
  input  wire logic [15:0] az,
  input  wire logic signed [14:0] alt,
  input  wire hlc_pkg::point_t prv,
  input  wire hlc_pkg::point_t nxt,
  input  wire logic [1:0]  mode,
  output logic             above
);
  // CMP_ZERO: compare to zero, CMP_POINT: compare to nxt.alt, CMP_INTERP: interpolate
  logic signed [16:0] dalt_r, rise_r;
  logic signed [17:0] span_r, off_r;
  logic signed [16:0] da, ri;
  logic signed [17:0] sp, of;
  always_comb begin
    da = 17'(alt) - 17'(prv.alt);
    ri = 17'(nxt.alt) - 17'(prv.alt);
    sp = $signed({2'b0, nxt.az}) - $signed({2'b0, prv.az});
    if (nxt.az < prv.az) sp = sp + $signed({1'b0, hlc_pkg::FULL_TURN});
    of = $signed({2'b0, az}) - $signed({2'b0, prv.az});
    if (az < prv.az) of = of + $signed({1'b0, hlc_pkg::FULL_TURN});
    if (mode != hlc_pkg::CMP_INTERP) begin
      da = (mode == hlc_pkg::CMP_ZERO) ? 17'(alt) : 17'(alt) - 17'(nxt.alt);
      sp = 18'sd1;
      ri = '0;
      of = '0;
    end
  end
  always_ff @(posedge clk) begin
    dalt_r <= da;
    rise_r <= ri;
    span_r <= sp;
    off_r <= of;
  end
  logic signed [34:0] lhs, rhs;
  assign lhs = 35'(dalt_r) * 35'(span_r);
  assign rhs = 35'(rise_r) * 35'(off_r);
  assign above = (lhs >= rhs);
endmodule
`default_nettype wire

// ===== design/horizon_limit_checker_core.sv =====
`default_nettype none
// ----------------------------------------------------------------------------
// horizon_limit_checker_core
// Horizon table held in a row of shifting cells with an exact limit check.
// ----------------------------------------------------------------------------
// Issue an item with start while busy is low. Whatever the table holds, clear
// and delete go straight to the apply step; insert first has every cell compare
// its azimuth with the key, then the shift runs; check compares, then the
// neighbors are picked and the two-stage multiply compare runs. busy drops the
// cycle after the result, so no new item is taken until the last one is
// through. out_valid pulses for one cycle with the result; the receiver cannot
// stall it.
module horizon_limit_checker_core (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        start,
  output logic             busy,
  input  wire logic [1:0]  in_func,
  input  wire logic [15:0] in_azimuth,
  input  wire logic signed [14:0] in_altitude,
  input  wire logic [5:0]  in_point_index,
  input  wire logic [1:0]  in_mount_state,
  input  wire logic        in_in_goto,
  input  wire logic        cfg_we,
  input  wire logic [1:0]  cfg_index,
  input  wire logic        cfg_wdata,
  output logic             out_valid,
  output logic [1:0]       out_status,
  output logic [5:0]       out_point_rank,
  output logic [6:0]       out_point_count,
  output logic             out_in_limits,
  output logic             out_goto_allowed,
  output logic             out_abort_mount,
  output logic             out_first_warning
);
  localparam int IW = hlc_pkg::IDX_W;
  localparam int CW = hlc_pkg::CNT_W;
  localparam int NP = hlc_pkg::MAX_POINTS;

  typedef enum logic [5:0] {
    S_IDLE = 6'b000001, S_SCAN = 6'b000010, S_APPLY = 6'b000100,
    S_PREP = 6'b001000, S_MUL = 6'b010000, S_DONE = 6'b100000
  } state_t;
  state_t st_r, st_nxt;

  logic [1:0] func_r;
  logic [15:0] az_r;
  logic signed [14:0] alt_r;
  logic [IW-1:0] pidx_r;
  logic [1:0] ms_r;
  logic goto_r;
  logic [CW-1:0] cnt_r, rank_r;
  logic warn_sent_r;
  logic c_trk_r, c_slw_r, c_gto_r, c_gd_r;
  logic [1:0] status_r;
  logic inl_r, abt_r, wrn_r, gok_r;
  logic abt_nx;

  hlc_pkg::point_t pts [NP];
  hlc_pkg::cell_cmd_t cmd;
  logic [NP-1:0] vld_c, lt_c, eq_c, lt_r;

  for (genvar g = 0; g < NP; g++) begin : g_cell
    hlc_pkg::point_t lo, hi;
    if (g == 0) begin : g_lo0
      assign lo = pts[0];
    end else begin : g_lo
      assign lo = pts[g-1];
    end
    if (g == NP - 1) begin : g_hiN
      assign hi = pts[g];
    end else begin : g_hi
      assign hi = pts[g+1];
    end
    hlc_cell u_cell (.clk(clk), .pos(IW'(g)), .cmd(cmd), .lower(lo), .upper(hi),
      .pt(pts[g]));
    assign vld_c[g] = (CW'(g) < cnt_r);
    assign lt_c[g] = vld_c[g] && (pts[g].az < az_r);
    assign eq_c[g] = vld_c[g] && (pts[g].az == az_r);
  end

  logic [16:0] az_in;
  assign az_in = ({1'b0, in_azimuth} >= hlc_pkg::FULL_TURN) ?
                 {1'b0, in_azimuth} - hlc_pkg::FULL_TURN : {1'b0, in_azimuth};

  // rank boundary and neighbor select from the registered compare row
  logic [NP:0] bnd, vld_x;
  logic [NP-1:0] nsel, psel, last;
  logic [CW-1:0] rank_c;
  logic wrap, nx_zero;
  hlc_pkg::point_t nxt_pt, prv_pt;
  always_comb begin
    vld_x = {1'b0, vld_c};
    bnd[0] = !lt_r[0];
    for (int g = 1; g < NP; g++) bnd[g] = lt_r[g-1] && !lt_r[g];
    bnd[NP] = lt_r[NP-1];
    rank_c = '0;
    for (int g = 0; g <= NP; g++) begin
      if (bnd[g]) rank_c = rank_c | CW'(g);
    end
    wrap = ~|(vld_c & ~lt_r);
    nx_zero = wrap || bnd[0];
    nxt_pt = '0;
    prv_pt = '0;
    for (int g = 0; g < NP; g++) begin
      last[g] = vld_x[g] && !vld_x[g+1];
      nsel[g] = wrap ? (g == 0) : bnd[g];
      psel[g] = nx_zero ? last[g] : bnd[g+1];
      if (nsel[g]) nxt_pt = nxt_pt | pts[g];
      if (psel[g]) prv_pt = prv_pt | pts[g];
    end
  end

  logic [1:0] mode;
  always_comb begin
    if (cnt_r == '0) mode = hlc_pkg::CMP_ZERO;
    else if (cnt_r == CW'(1) || nxt_pt.az == az_r || prv_pt.alt == nxt_pt.alt)
      mode = hlc_pkg::CMP_POINT;
    else mode = hlc_pkg::CMP_INTERP;
  end
  logic above;
  hlc_interp u_interp (.clk(clk), .az(az_r), .alt(alt_r), .prv(prv_pt), .nxt(nxt_pt),
    .mode(mode), .above(above));

  always_comb begin
    cmd = '0;
    cmd.az = az_r;
    cmd.alt = alt_r;
    cmd.rank = (func_r == hlc_pkg::FN_DELETE) ? pidx_r : rank_c[IW-1:0];
    if (st_r == S_APPLY) begin
      cmd.ins = (func_r == hlc_pkg::FN_INSERT) && status_r == hlc_pkg::ST_OK;
      cmd.del = (func_r == hlc_pkg::FN_DELETE) && status_r == hlc_pkg::ST_OK;
    end
  end

  always_comb begin
    st_nxt = st_r;
    unique case (st_r)
      S_IDLE: if (start) begin
        st_nxt = (in_func == hlc_pkg::FN_INSERT || in_func == hlc_pkg::FN_CHECK) ?
                 S_SCAN : S_APPLY;
      end
      S_SCAN: st_nxt = (func_r == hlc_pkg::FN_CHECK) ? S_PREP : S_APPLY;
      S_APPLY: st_nxt = S_DONE;
      S_PREP: st_nxt = S_MUL;
      S_MUL: st_nxt = S_DONE;
      S_DONE: st_nxt = S_IDLE;
      default: st_nxt = S_IDLE;
    endcase
  end

  logic inl;
  assign inl = above;

  always_comb begin
    abt_nx = (ms_r == hlc_pkg::MS_TRACK && c_trk_r) ||
             (ms_r == hlc_pkg::MS_SLEW && c_slw_r && !goto_r) ||
             (ms_r == hlc_pkg::MS_SLEW && c_gto_r && goto_r);
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      st_r <= S_IDLE;
      cnt_r <= '0;
      warn_sent_r <= 1'b0;
      c_trk_r <= 1'b0; c_slw_r <= 1'b0; c_gto_r <= 1'b0; c_gd_r <= 1'b0;
    end else begin
      st_r <= st_nxt;
      if (cfg_we) begin
        unique case (cfg_index)
          hlc_pkg::CFG_TRACK: c_trk_r <= cfg_wdata;
          hlc_pkg::CFG_SLEW: c_slw_r <= cfg_wdata;
          hlc_pkg::CFG_GOTO: c_gto_r <= cfg_wdata;
          hlc_pkg::CFG_GDIS: c_gd_r <= cfg_wdata;
          default: ;
        endcase
      end
      if (st_r == S_APPLY) begin
        if (func_r == hlc_pkg::FN_CLEAR) cnt_r <= '0;
        else if (cmd.ins) cnt_r <= cnt_r + CW'(1);
        else if (cmd.del) cnt_r <= cnt_r - CW'(1);
      end
      if (st_r == S_MUL) begin
        if (inl) warn_sent_r <= 1'b0;
        else if (!abt_nx && !warn_sent_r) warn_sent_r <= 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (st_r == S_IDLE && start) begin
      func_r <= in_func;
      az_r <= az_in[15:0];
      alt_r <= in_altitude;
      pidx_r <= in_point_index[IW-1:0];
      ms_r <= in_mount_state;
      goto_r <= in_in_goto;
      rank_r <= '0;
      inl_r <= 1'b0; abt_r <= 1'b0; wrn_r <= 1'b0; gok_r <= 1'b0;
      status_r <= (in_func == hlc_pkg::FN_DELETE && CW'(in_point_index) >= cnt_r) ?
                  hlc_pkg::ST_BADIDX : hlc_pkg::ST_OK;
    end
    if (st_r == S_SCAN) begin
      lt_r <= lt_c;
      if (func_r == hlc_pkg::FN_INSERT) begin
        if (|eq_c) status_r <= hlc_pkg::ST_DUP;
        else if (cnt_r == CW'(NP)) status_r <= hlc_pkg::ST_FULL;
      end
    end
    if (st_r == S_APPLY) rank_r <= rank_c;
    if (st_r == S_MUL) begin
      inl_r <= inl;
      gok_r <= inl | c_gd_r;
      abt_r <= !inl && abt_nx;
      wrn_r <= !inl && !abt_nx && !warn_sent_r;
    end
  end

  assign busy = (st_r != S_IDLE);
  assign out_valid = (st_r == S_DONE);
  assign out_status = status_r;
  assign out_point_rank = (func_r == hlc_pkg::FN_INSERT && status_r == hlc_pkg::ST_OK) ?
                          6'(rank_r) : 6'd0;
  assign out_point_count = 7'(cnt_r);
  assign out_in_limits = inl_r;
  assign out_goto_allowed = gok_r;
  assign out_abort_mount = abt_r;
  assign out_first_warning = wrn_r;

  a_cnt_max: assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(NP)) else $error("count overflow");
  a_ack: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |=> !busy) else $error("busy after result");
  a_abt_warn: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> !(out_abort_mount && out_first_warning)) else $error("abort and warn");
endmodule
`default_nettype wire
